// ----- rtl/core/lkv_pkg.sv -----
// lkv_pkg: shared types and constants for the lru key-value cache
// used by lkv_cell and lru_key_value_cache_top; depends on nothing else
package lkv_pkg;

    localparam int LKV_ENTRIES = 16;
    localparam int KEY_W       = 32;
    localparam int VAL_W       = 32;
    localparam int CAP_W       = 5;
    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    typedef enum logic
    {
        CMD_GET = 1'b0,
        CMD_PUT = 1'b1
    } cmd_t;

    // broadcast to every cell of the chain for one request
    typedef struct packed
    {
        logic [KEY_W-1:0] key;
        logic             move_all;
        logic             hit_move;
    } cell_ctl_t;

endpackage

// ----- rtl/core/lkv_cell.sv -----
// lkv_cell: one position of the recency-ordered entry chain
// holds a key and value, compares against the request, shifts from its upper neighbor
// depends on lkv_pkg
module lkv_cell
(
    input  logic                      clk,
    input  lkv_pkg::cell_ctl_t        ctl,
    input  logic                      entry_valid,
    input  logic [lkv_pkg::KEY_W-1:0] up_key,
    input  logic [lkv_pkg::VAL_W-1:0] up_value,
    input  logic                      match_in,
    input  logic [lkv_pkg::VAL_W-1:0] sel_in,
    output logic [lkv_pkg::KEY_W-1:0] key,
    output logic [lkv_pkg::VAL_W-1:0] value,
    output logic                      match_out,
    output logic [lkv_pkg::VAL_W-1:0] sel_out
);
    import lkv_pkg::*;

    logic [KEY_W-1:0] key_reg;
    logic [KEY_W-1:0] key_next;
    logic [VAL_W-1:0] value_reg;
    logic [VAL_W-1:0] value_next;
    logic             match;
    logic             shift;

    always_comb
    begin
        match      = entry_valid && (key_reg == ctl.key);
        match_out  = match | match_in;
        sel_out    = sel_in | (match ? value_reg : '0);
        // a hit moves this position and every more recent one down by one
        shift      = ctl.move_all | (ctl.hit_move & match_out);
        key_next   = shift ? up_key : key_reg;
        value_next = shift ? up_value : value_reg;
    end

    always_ff @(posedge clk)
    begin
        key_reg   <= key_next;
        value_reg <= value_next;
    end

    assign key   = key_reg;
    assign value = value_reg;

endmodule

// ----- rtl/core/lru_key_value_cache_top.sv -----
// lru_key_value_cache_top: fully associative key-value cache, lru replacement
// channel    dir  signals                                  contents
// s_*        in   s_tvalid s_tready s_tdata s_tuser         request: key, value, command
// m_*        out  m_tvalid m_tready m_tdata m_tuser         result: read_value, hit
// cfg_*      in   cfg_valid cfg_ready cfg_data              capacity register
// one request per cycle while the output is not stalled; the result appears in the cycle after
// its request is taken, from the combinational compare across the cell chain
// reset empties the cache at once (entry count to zero), capacity returns to 16
// a stalled result holds in the output register; a new request is taken only
// when that register is empty or being drained in the same cycle
// depends on lkv_pkg and lkv_cell
module lru_key_value_cache_top
#(
    parameter int ENTRIES = lkv_pkg::LKV_ENTRIES
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [63:0]               s_tdata,   // key [31:0], value [63:32]
    input  logic                      s_tuser,   // command
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [31:0]               m_tdata,   // read_value [31:0]
    output logic                      m_tuser,   // hit
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [lkv_pkg::CAP_W-1:0] cfg_data   // capacity
);
    import lkv_pkg::*;

    localparam int CNT_W = $clog2(ENTRIES + 1);
    localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

    logic [CAP_W-1:0] cap_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             out_valid_reg;
    logic             hit_reg;
    logic [VAL_W-1:0] rdata_reg;

    logic             accept;
    logic [KEY_W-1:0] req_key;
    logic [VAL_W-1:0] req_value;
    cmd_t             req_cmd;
    logic             hit;
    logic             evict;
    logic [CMP_W-1:0] eff_cap;
    logic [VAL_W-1:0] front_value;
    cell_ctl_t        ctl;

    logic [KEY_W-1:0] cell_key   [ENTRIES];
    logic [VAL_W-1:0] cell_value [ENTRIES];
    logic             match_chain [ENTRIES+1];
    logic [VAL_W-1:0] sel_chain   [ENTRIES+1];

    assign s_tready  = !out_valid_reg || m_tready;
    assign accept    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign req_key   = s_tdata[31:0];
    assign req_value = s_tdata[63:32];
    assign req_cmd   = cmd_t'(s_tuser);

    assign match_chain[ENTRIES] = 1'b0;
    assign sel_chain[ENTRIES]   = '0;
    assign hit                  = match_chain[0];

    always_comb
    begin
        if (cap_reg == '0)
            eff_cap = CMP_W'(1);
        else if (CMP_W'(cap_reg) > CMP_W'(ENTRIES))
            eff_cap = CMP_W'(ENTRIES);
        else
            eff_cap = CMP_W'(cap_reg);

        evict = (CMP_W'(count_reg) >= eff_cap) || (count_reg == CNT_W'(ENTRIES));

        ctl.key      = req_key;
        ctl.move_all = accept && (req_cmd == CMD_PUT) && !hit;
        ctl.hit_move = accept && hit;

        front_value = (req_cmd == CMD_PUT) ? req_value : sel_chain[0];

        count_next = count_reg;
        if (ctl.move_all && !evict)
            count_next = count_reg + CNT_W'(1);
    end

    for (genvar i = 0; i < ENTRIES; i++)
    begin : g_cell
        logic [KEY_W-1:0] up_key;
        logic [VAL_W-1:0] up_value;

        if (i == 0)
        begin : g_front
            assign up_key   = req_key;
            assign up_value = front_value;
        end
        else
        begin : g_link
            assign up_key   = cell_key[i-1];
            assign up_value = cell_value[i-1];
        end

        lkv_cell u_cell
        (
            .clk         (clk),
            .ctl         (ctl),
            .entry_valid (count_reg > CNT_W'(i)),
            .up_key      (up_key),
            .up_value    (up_value),
            .match_in    (match_chain[i+1]),
            .sel_in      (sel_chain[i+1]),
            .key         (cell_key[i]),
            .value       (cell_value[i]),
            .match_out   (match_chain[i]),
            .sel_out     (sel_chain[i])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg       <= CAP_RESET;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                cap_reg <= cfg_data;
            count_reg <= count_next;
            if (accept)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            hit_reg   <= hit;
            rdata_reg <= (hit && (req_cmd == CMD_GET)) ? sel_chain[0] : '0;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = rdata_reg;
    assign m_tuser  = hit_reg;

endmodule

// ----- test/lkv_checker.sv -----
// lkv_checker: watches the request, result and capacity channels of the lru key-value cache,
// keeps its own recency-ordered copy of the cache and compares each result as it is taken
// depends on lkv_pkg
module lkv_checker
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      s_tvalid,
    input  logic                      s_tready,
    input  logic [63:0]               s_tdata,
    input  logic                      s_tuser,
    input  logic                      m_tvalid,
    input  logic                      m_tready,
    input  logic [31:0]               m_tdata,
    input  logic                      m_tuser,
    input  logic                      cfg_valid,
    input  logic                      cfg_ready,
    input  logic [lkv_pkg::CAP_W-1:0] cfg_data,
    output int                        fails,
    output int                        pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import lkv_pkg::*;

    typedef struct packed
    {
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] data;
    } line_t;

    typedef struct packed
    {
        logic             hit;
        logic [VAL_W-1:0] read_value;
    } lookup_t;

    // index 0 is the most recent line
    line_t            lru_lines[$];
    lookup_t          lookups_due[$];
    logic [CAP_W-1:0] capacity;

    function automatic int live_limit(logic [CAP_W-1:0] cap);
        if (cap == 0)
            return 1;
        if (cap > LKV_ENTRIES)
            return LKV_ENTRIES;
        return int'(cap);
    endfunction

    function automatic lookup_t cache_access(cmd_t cmd, logic [KEY_W-1:0] key,
                                             logic [VAL_W-1:0] data);
        lookup_t res;
        line_t   ln;
        int      where;
        res.hit        = 1'b0;
        res.read_value = '0;
        where          = -1;
        foreach (lru_lines[i])
        begin
            if (where < 0 && lru_lines[i].key == key)
                where = i;
        end
        if (where >= 0)
        begin
            ln = lru_lines[where];
            lru_lines.delete(where);
            res.hit = 1'b1;
            if (cmd == CMD_GET)
                res.read_value = ln.data;
            else
                ln.data = data;
            lru_lines.insert(0, ln);
        end
        else if (cmd == CMD_PUT)
        begin
            // full, or capacity lowered below the count: drop the oldest line
            if (lru_lines.size() >= live_limit(capacity))
                lru_lines.delete(lru_lines.size() - 1);
            ln.key  = key;
            ln.data = data;
            lru_lines.insert(0, ln);
        end
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        lookup_t due;
        if (!rst_n)
        begin
            lru_lines.delete();
            lookups_due.delete();
            capacity = CAP_RESET;
            fails    = 0;
            pending  = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (lookups_due.size() == 0)
                begin
                    $error("result with no request outstanding: hit %0b read_value %h",
                           m_tuser, m_tdata);
                    fails++;
                end
                else
                begin
                    due = lookups_due.pop_front();
                    if (m_tuser !== due.hit)
                    begin
                        $error("hit mismatch: expected %0b, got %0b", due.hit, m_tuser);
                        fails++;
                    end
                    if (m_tdata !== due.read_value)
                    begin
                        $error("read_value mismatch: expected %h, got %h",
                               due.read_value, m_tdata);
                        fails++;
                    end
                end
            end
            if (cfg_valid && cfg_ready)
                capacity = cfg_data;
            if (s_tvalid && s_tready)
                lookups_due.push_back(cache_access(cmd_t'(s_tuser), s_tdata[31:0],
                                                   s_tdata[63:32]));
            pending = lookups_due.size();
        end
    end

endmodule

// ----- test/tb_top.sv -----
// tb_top: drives gets and puts into lru_key_value_cache_top under bursty traffic and output
// stalls, changes the capacity between phases and reports the verdict of lkv_checker
// depends on lkv_pkg, lru_key_value_cache_top and lkv_checker
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import lkv_pkg::*;

    localparam int POOL_SIZE   = 24;
    localparam int PHASES      = 10;
    localparam int PHASE_ITEMS = 160;
    localparam int HOLD_CYCLES = 120;
    localparam int QUIET_LIMIT = 1000;

    logic             clk       = 1'b0;
    logic             rst_n     = 1'b0;
    logic             s_tvalid  = 1'b0;
    logic             s_tready;
    logic [63:0]      s_tdata   = '0;
    logic             s_tuser   = 1'b0;
    logic             m_tvalid;
    logic             m_tready  = 1'b0;
    logic [31:0]      m_tdata;
    logic             m_tuser;
    logic             cfg_valid = 1'b0;
    logic             cfg_ready;
    logic [CAP_W-1:0] cfg_data  = '0;

    int               fails;
    int               pending;
    int               quiet_cycles = 0;
    bit               hold_req     = 1'b0;
    bit               hold_done    = 1'b0;
    logic [KEY_W-1:0] key_pool[POOL_SIZE];
    int               pool_n;

    lru_key_value_cache_top i_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    lkv_checker i_checker
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .fails     (fails),
        .pending   (pending)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        while (quiet_cycles < QUIET_LIMIT)
            @(posedge clk);
        $display("CHECK FAILED");
        $finish;
    end

    // result side: stall pattern of its own, one long hold-off on request
    initial
    begin
        int mode;
        int span;
        span = 0;
        mode = 0;
        forever
        begin
            @(negedge clk);
            if (hold_req && !hold_done)
            begin
                m_tready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_done = 1'b1;
            end
            if (span == 0)
            begin
                mode = $urandom_range(0, 3);
                span = $urandom_range(10, 80);
            end
            span--;
            case (mode)
                0: m_tready = 1'b1;
                1: m_tready = $urandom_range(0, 1);
                2: m_tready = ($urandom_range(0, 3) != 0);
                default: m_tready = ($urandom_range(0, 4) == 0);
            endcase
        end
    end

    task automatic issue(cmd_t cmd, logic [KEY_W-1:0] key, logic [VAL_W-1:0] data);
        @(negedge clk);
        s_tvalid = 1'b1;
        s_tuser  = cmd;
        s_tdata  = {data, key};
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    task automatic settle();
        @(negedge clk);
        s_tvalid = 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (2) @(negedge clk);
    endtask

    task automatic set_capacity(logic [CAP_W-1:0] cap);
        settle();
        cfg_valid = 1'b1;
        cfg_data  = cap;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    function automatic logic [31:0] edge_word();
        case ($urandom_range(0, 3))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'h0000_0000;
            default: return 32'hFFFF_FFFF;
        endcase
    endfunction

    function automatic logic [KEY_W-1:0] pick_key();
        if ($urandom_range(0, 9) == 0)
            return $urandom;
        return key_pool[$urandom_range(0, pool_n - 1)];
    endfunction

    function automatic logic [VAL_W-1:0] pick_value();
        if ($urandom_range(0, 15) == 0)
            return edge_word();
        return $urandom;
    endfunction

    task automatic run_phase(int count, bit gapless);
        int   n;
        int   burst_left;
        int   gap;
        cmd_t cmd;
        burst_left = 0;
        for (n = 0; n < count; n++)
        begin
            if (burst_left == 0)
            begin
                burst_left = $urandom_range(1, 16);
                gap = gapless ? 0 : $urandom_range(0, 6);
                if (gap > 0)
                begin
                    @(negedge clk);
                    s_tvalid = 1'b0;
                    repeat (gap - 1) @(negedge clk);
                end
            end
            burst_left--;
            cmd = $urandom_range(0, 1) ? CMD_PUT : CMD_GET;
            issue(cmd, pick_key(), pick_value());
        end
        settle();
    endtask

    initial
    begin
        logic [CAP_W-1:0] cap_plan[PHASES];
        int               k;
        cap_plan = '{5'd16, 5'd1, 5'd4, 5'd16, 5'd2, 5'd11, 5'd1, 5'd8, 5'd16, 5'd3};
        key_pool[0] = 32'h8000_0000;
        key_pool[1] = 32'h7FFF_FFFF;
        key_pool[2] = 32'h0000_0000;
        key_pool[3] = 32'hFFFF_FFFF;
        for (k = 4; k < POOL_SIZE; k++)
            key_pool[k] = $urandom;
        pool_n = POOL_SIZE;

        repeat (8) @(negedge clk);
        rst_n = 1'b1;

        // directed: extremes of key and value at the reset capacity
        issue(CMD_GET, 32'h0000_0000, 32'hFFFF_FFFF);
        issue(CMD_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
        issue(CMD_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
        issue(CMD_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        issue(CMD_PUT, 32'h0000_0000, 32'h0000_0000);
        issue(CMD_GET, 32'h8000_0000, 32'h0000_0000);
        issue(CMD_GET, 32'h7FFF_FFFF, 32'h0000_0000);
        issue(CMD_PUT, 32'h7FFF_FFFF, 32'h1234_5678);
        issue(CMD_GET, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
        issue(CMD_GET, 32'hFFFF_FFFF, 32'h0000_0000);
        issue(CMD_GET, 32'h0000_0000, 32'h0000_0000);
        issue(CMD_GET, 32'h0000_0001, 32'h5555_AAAA);

        // capacity below the live count: each new key evicts the oldest one
        set_capacity(5'd2);
        issue(CMD_PUT, 32'h0000_0005, 32'hAAAA_5555);
        issue(CMD_GET, 32'h8000_0000, 32'h0000_0000);
        issue(CMD_PUT, 32'h0000_0006, 32'h0F0F_F0F0);
        issue(CMD_GET, 32'hFFFF_FFFF, 32'h0000_0000);
        issue(CMD_GET, 32'h7FFF_FFFF, 32'h0000_0000);
        set_capacity(5'd1);
        issue(CMD_PUT, 32'h0000_0007, 32'h0000_0001);
        issue(CMD_GET, 32'h0000_0000, 32'h0000_0000);
        issue(CMD_GET, 32'h0000_0007, 32'h0000_0000);

        for (k = 0; k < PHASES; k++)
        begin
            set_capacity(cap_plan[k]);
            repeat (4) key_pool[$urandom_range(4, POOL_SIZE - 1)] = $urandom;
            pool_n = int'(cap_plan[k]) + $urandom_range(1, 5);
            if (pool_n > POOL_SIZE)
                pool_n = POOL_SIZE;
            if (k == 3)
                hold_req = 1'b1;
            run_phase(PHASE_ITEMS, (k == 3) || (k == 7));
        end

        settle();
        if (fails == 0 && pending == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/core/lkv_pkg.sv
rtl/core/lkv_cell.sv
rtl/core/lru_key_value_cache_top.sv
test/lkv_checker.sv
test/tb_top.sv
